@@ rtl/fec_pkg.sv @@
package fec_pkg;

  localparam int FIELD_W           = 48;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 4;
  localparam int MAX_INTERVALS_DEF = 32;
  localparam int ADDR_BITS_DEF     = 48;

  typedef enum logic [OP_W-1:0] {
    OP_REPORT = 2'd0,
    OP_LIST   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 4'd0,
    ST_NEW     = 4'd1,
    ST_LEFT    = 4'd2,
    ST_RIGHT   = 4'd3,
    ST_BOTH    = 4'd4,
    ST_FULL    = 4'd5,
    ST_DUP     = 4'd6,
    ST_ENTRY   = 4'd7,
    ST_EMPTY   = 4'd8,
    ST_CLEARED = 4'd9
  } status_t;

endpackage

@@ rtl/fec_if.sv @@
interface fec_in_if;
  import fec_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] hole_start;
  logic [FIELD_W-1:0] hole_length;

  modport source (output valid, op, hole_start, hole_length, input ready);
  modport sink   (input valid, op, hole_start, hole_length, output ready);
endinterface

interface fec_out_if;
  import fec_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  out_start;
  logic [FIELD_W-1:0]  out_length;
  logic                last;

  modport source (output valid, status, out_start, out_length, last, input ready);
  modport sink   (input valid, status, out_start, out_length, last, output ready);
endinterface

@@ rtl/free_extent_coalescer_core.sv @@
// Sorted table of up to MAX_INTERVALS free address intervals, held in a
// single-port-read, single-port-write memory and worked on by one shared
// adder/comparator under a small sequencer; one item is taken at a time and
// in_if.ready is low until its last result has been taken. A report item scans
// the table from the bottom, reading each entry whose start lies below the
// hole and stopping at the first one that does not, then decides and sums,
// and an insert or a two-sided merge then moves every entry above the hole
// with one read and one write each before the result is offered.
// A list item reads the entries in turn and gives one result per entry, the
// next read waiting until the previous result has been taken; clear and unused
// opcodes go straight to their status result. The memory read port is the
// bottleneck throughout. Lengths saturate at the all-ones address value.
module free_extent_coalescer_core #(
  parameter int MAX_INTERVALS = fec_pkg::MAX_INTERVALS_DEF,
  parameter int ADDR_BITS     = fec_pkg::ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fec_in_if.sink    in_if,
  fec_out_if.source out_if
);
  import fec_pkg::*;

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int A     = ADDR_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LEFT,
    S_RIGHT,
    S_DUP,
    S_SUM1,
    S_SUM2,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_LIST_RD,
    S_LIST_CAP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] sh_r, sh_nxt;
  logic [A-1:0] addr_r, addr_nxt, len_r, len_nxt;
  logic [A-1:0] prev_s_r, prev_s_nxt, prev_l_r, prev_l_nxt;
  logic [A-1:0] cur_s_r, cur_s_nxt, cur_l_r, cur_l_nxt;
  logic [A-1:0] acc_r, acc_nxt;
  logic left_r, left_nxt, right_r, right_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t out_status_r, out_status_nxt;
  logic [FIELD_W-1:0] out_start_r, out_start_nxt, out_len_r, out_len_nxt;

  // memory: {start, length}
  logic [2*A-1:0] mem [MAX_INTERVALS];
  logic [2*A-1:0] rd_q;
  logic           rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [2*A-1:0] wr_data;
  logic [A-1:0]   rd_s, rd_l;

  logic [A-1:0] alu_a, alu_b, alu_wrap, alu_sat;
  logic         alu_lt, alu_eq;

  logic [FIELD_W+A-1:0] in_start_ext, in_len_ext;
  logic [FIELD_W+A-1:0] rd_s_ext, rd_l_ext;
  logic [A-1:0]         in_start_m, in_len_m;
  logic [CNT_W-1:0]     pos_inc, sh_inc, sh_dec, pos_dec;
  logic                 has_prev, has_cur;

  assign rd_s = rd_q[2*A-1:A];
  assign rd_l = rd_q[A-1:0];

  // fields are taken modulo 2^ADDR_BITS; stored values leave on 48-bit fields
  assign in_start_ext = {{A{1'b0}}, in_if.hole_start};
  assign in_len_ext   = {{A{1'b0}}, in_if.hole_length};
  assign in_start_m   = in_start_ext[A-1:0];
  assign in_len_m     = in_len_ext[A-1:0];
  assign rd_s_ext     = {{FIELD_W{1'b0}}, rd_s};
  assign rd_l_ext     = {{FIELD_W{1'b0}}, rd_l};

  assign pos_inc  = pos_r + 1'b1;
  assign pos_dec  = pos_r - 1'b1;
  assign sh_inc   = sh_r + 1'b1;
  assign sh_dec   = sh_r - 1'b1;
  assign has_prev = pos_r != '0;
  assign has_cur  = pos_r != cnt_r;

  fec_alu #(.W(A)) u_alu (
    .a        (alu_a),
    .b        (alu_b),
    .sum_wrap (alu_wrap),
    .sum_sat  (alu_sat),
    .lt       (alu_lt),
    .eq       (alu_eq)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_SCAN_CHK: begin
        alu_a = rd_s;
        alu_b = addr_r;
      end
      S_LEFT: begin
        alu_a = prev_s_r;
        alu_b = prev_l_r;
      end
      S_RIGHT: begin
        alu_a = addr_r;
        alu_b = len_r;
      end
      S_DUP: begin
        alu_a = cur_s_r;
        alu_b = addr_r;
      end
      S_SUM1: begin
        if (left_r && right_r) begin
          alu_a = len_r;
          alu_b = cur_l_r;
        end else if (left_r) begin
          alu_a = prev_l_r;
          alu_b = len_r;
        end else begin
          alu_a = cur_l_r;
          alu_b = len_r;
        end
      end
      S_SUM2: begin
        alu_a = prev_l_r;
        alu_b = acc_r;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    sh_nxt         = sh_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    prev_s_nxt     = prev_s_r;
    prev_l_nxt     = prev_l_r;
    cur_s_nxt      = cur_s_r;
    cur_l_nxt      = cur_l_r;
    acc_nxt        = acc_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = pos_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = pos_r[IDX_W-1:0];
    wr_data        = {addr_r, len_r};

    // unless a state overrides, a finished item shows a status-only result
    if (state_r != S_OUT && state_r != S_LIST_CAP) begin
      out_start_nxt = '0;
      out_len_nxt   = '0;
      out_last_nxt  = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          pos_nxt = '0;
          case (op_t'(in_if.op))
            OP_REPORT: begin
              addr_nxt = in_start_m;
              len_nxt  = in_len_m;
              if (in_start_m == '0 || in_len_m == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_IGNORED;
                state_nxt      = S_OUT;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            OP_LIST: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                state_nxt      = S_OUT;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            OP_CLEAR: begin
              cnt_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
              state_nxt      = S_OUT;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_IGNORED;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (!has_cur) begin
          state_nxt = S_LEFT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (alu_lt) begin
          prev_s_nxt = rd_s;
          prev_l_nxt = rd_l;
          pos_nxt    = pos_inc;
          state_nxt  = S_SCAN_RD;
        end else begin
          cur_s_nxt = rd_s;
          cur_l_nxt = rd_l;
          state_nxt = S_LEFT;
        end
      end

      S_LEFT: begin
        left_nxt  = has_prev && (alu_wrap == addr_r);
        state_nxt = S_RIGHT;
      end

      S_RIGHT: begin
        right_nxt = has_cur && (alu_wrap == cur_s_r);
        state_nxt = (left_r || right_nxt) ? S_SUM1 : S_DUP;
      end

      S_SUM1: begin
        acc_nxt = alu_sat;
        if (left_r && right_r) begin
          state_nxt = S_SUM2;
        end else if (left_r) begin
          wr_en          = 1'b1;
          wr_addr        = pos_dec[IDX_W-1:0];
          wr_data        = {prev_s_r, alu_sat};
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_LEFT;
          state_nxt      = S_OUT;
        end else begin
          wr_en          = 1'b1;
          wr_data        = {addr_r, alu_sat};
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_RIGHT;
          state_nxt      = S_OUT;
        end
      end

      S_SUM2: begin
        wr_en     = 1'b1;
        wr_addr   = pos_dec[IDX_W-1:0];
        wr_data   = {prev_s_r, alu_sat};
        sh_nxt    = pos_r;
        state_nxt = S_SHDN_RD;
      end

      // close the gap left by the right-hand neighbor
      S_SHDN_RD: begin
        if (sh_inc == cnt_r) begin
          cnt_nxt        = cnt_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_BOTH;
          state_nxt      = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = sh_inc[IDX_W-1:0];
          state_nxt = S_SHDN_WR;
        end
      end

      S_SHDN_WR: begin
        wr_en     = 1'b1;
        wr_addr   = sh_r[IDX_W-1:0];
        wr_data   = rd_q;
        sh_nxt    = sh_inc;
        state_nxt = S_SHDN_RD;
      end

      S_DUP: begin
        if (has_cur && alu_eq) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUP;
          state_nxt      = S_OUT;
        end else if (cnt_r == CNT_W'(MAX_INTERVALS)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end else begin
          sh_nxt    = cnt_r;
          state_nxt = S_SHUP_RD;
        end
      end

      // open a slot at pos, top entry first
      S_SHUP_RD: begin
        if (sh_r == pos_r) begin
          wr_en          = 1'b1;
          wr_data        = {addr_r, len_r};
          cnt_nxt        = cnt_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NEW;
          state_nxt      = S_OUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = sh_dec[IDX_W-1:0];
          state_nxt = S_SHUP_WR;
        end
      end

      S_SHUP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = sh_r[IDX_W-1:0];
        wr_data   = rd_q;
        sh_nxt    = sh_dec;
        state_nxt = S_SHUP_RD;
      end

      S_LIST_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LIST_CAP;
      end

      S_LIST_CAP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_ENTRY;
        out_start_nxt  = rd_s_ext[FIELD_W-1:0];
        out_len_nxt    = rd_l_ext[FIELD_W-1:0];
        out_last_nxt   = pos_inc == cnt_r;
        state_nxt      = S_OUT;
      end

      S_OUT: begin
        if (out_if.ready) begin
          out_valid_nxt = 1'b0;
          if (out_status_r == ST_ENTRY && !out_last_r) begin
            pos_nxt   = pos_inc;
            state_nxt = S_LIST_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    sh_r         <= sh_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    prev_s_r     <= prev_s_nxt;
    prev_l_r     <= prev_l_nxt;
    cur_s_r      <= cur_s_nxt;
    cur_l_r      <= cur_l_nxt;
    acc_r        <= acc_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_if.ready       = state_r == S_IDLE;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.out_start  = out_start_r;
  assign out_if.out_length = out_len_r;
  assign out_if.last       = out_last_r;

endmodule

@@ rtl/fec_alu.sv @@
module fec_alu #(
  parameter int W = fec_pkg::ADDR_BITS_DEF
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] sum_wrap,
  output logic [W-1:0] sum_sat,
  output logic         lt,
  output logic         eq
);

  logic [W:0] sum;

  assign sum      = {1'b0, a} + {1'b0, b};
  assign sum_wrap = sum[W-1:0];
  // carry out means the true sum is past the all-ones limit
  assign sum_sat  = sum[W] ? {W{1'b1}} : sum[W-1:0];
  assign lt       = a < b;
  assign eq       = a == b;

endmodule

@@ rtl/fec_checker.sv @@
module fec_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fec_pkg::STATUS_W-1:0] status,
  input logic [fec_pkg::FIELD_W-1:0]  out_start,
  input logic [fec_pkg::FIELD_W-1:0]  out_length,
  input logic                         last
);
  import fec_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // one item at a time: no new item while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // only listed entries carry data, and every other status ends its item
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_ENTRY |-> last && out_start == '0 && out_length == '0)
    else $error("status-only result with data or without last");

endmodule

bind free_extent_coalescer_core fec_checker u_fec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .status     (out_if.status),
  .out_start  (out_if.out_start),
  .out_length (out_if.out_length),
  .last       (out_if.last)
);
